// ----- src/vlmr_pkg.sv -----
// Shared types and codes for the variable-length message ring.
// Used by vlmr_ctrl, vlmr_dp and the top level; no dependencies.
`timescale 1ns / 1ps

package vlmr_pkg;

    // item kinds on the input channel
    localparam logic [1:0] KIND_OPEN = 2'd0;
    localparam logic [1:0] KIND_PAY  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_SEQ_ERR  = 3'd4
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_HDR,
        S_PAY,
        S_RH0,
        S_RH1,
        S_RLEN,
        S_RCHK,
        S_RADDR,
        S_RDATA,
        S_RESP
    } state_t;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_RESULT,
        CMD_HDR,
        CMD_PAY,
        CMD_RD_H0,
        CMD_RD_H1,
        CMD_RD_LEN,
        CMD_RD_ZERO,
        CMD_RD_START,
        CMD_RD_ADDR,
        CMD_RD_DATA
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        cmd_t    cmd;
        status_t status;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       wr_open;
        logic       space_ok;
        logic       empty;
        logic       rd_at_hdr;
        logic       too_long;
        logic       len_zero;
        logic       hdr_done;
    } stat_t;

endpackage

// ----- src/vlmr_ctrl.sv -----
// Sequencer for the message ring: steps each item through decode,
// memory accesses and the response. Depends on vlmr_pkg.
`timescale 1ns / 1ps

module vlmr_ctrl
    import vlmr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.kind)
                    KIND_OPEN:
                    begin
                        if (stat.wr_open || !stat.space_ok)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_HDR;
                        end
                    end
                    KIND_PAY:
                    begin
                        state_next = stat.wr_open ? S_PAY : S_RESP;
                    end
                    KIND_READ:
                    begin
                        if (stat.empty)
                        begin
                            state_next = S_RESP;
                        end
                        else if (stat.rd_at_hdr)
                        begin
                            state_next = S_RH0;
                        end
                        else
                        begin
                            state_next = S_RADDR;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_HDR:
            begin
                if (stat.hdr_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_PAY:   state_next = S_RESP;
            S_RH0:   state_next = S_RH1;
            S_RH1:   state_next = S_RLEN;
            S_RLEN:  state_next = S_RCHK;
            S_RCHK:
            begin
                if (stat.too_long || stat.len_zero)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_RDATA;
                end
            end
            S_RADDR: state_next = S_RDATA;
            S_RDATA: state_next = S_RESP;
            S_RESP:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        ctl.cmd    = CMD_NONE;
        ctl.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.cmd = CMD_LATCH;
                end
            end
            S_DECODE:
            begin
                unique case (stat.kind)
                    KIND_OPEN:
                    begin
                        if (stat.wr_open)
                        begin
                            ctl.cmd    = CMD_RESULT;
                            ctl.status = ST_SEQ_ERR;
                        end
                        else if (!stat.space_ok)
                        begin
                            ctl.cmd    = CMD_RESULT;
                            ctl.status = ST_NO_SPACE;
                        end
                    end
                    KIND_PAY:
                    begin
                        if (!stat.wr_open)
                        begin
                            ctl.cmd    = CMD_RESULT;
                            ctl.status = ST_SEQ_ERR;
                        end
                    end
                    KIND_READ:
                    begin
                        if (stat.empty)
                        begin
                            ctl.cmd    = CMD_RESULT;
                            ctl.status = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        ctl.cmd    = CMD_RESULT;
                        ctl.status = ST_SEQ_ERR;
                    end
                endcase
            end
            S_HDR:   ctl.cmd = CMD_HDR;
            S_PAY:   ctl.cmd = CMD_PAY;
            S_RH0:   ctl.cmd = CMD_RD_H0;
            S_RH1:   ctl.cmd = CMD_RD_H1;
            S_RLEN:  ctl.cmd = CMD_RD_LEN;
            S_RCHK:
            begin
                if (stat.too_long)
                begin
                    ctl.cmd    = CMD_RESULT;
                    ctl.status = ST_TOO_LONG;
                end
                else if (stat.len_zero)
                begin
                    ctl.cmd = CMD_RD_ZERO;
                end
                else
                begin
                    ctl.cmd = CMD_RD_START;
                end
            end
            S_RADDR: ctl.cmd = CMD_RD_ADDR;
            S_RDATA: ctl.cmd = CMD_RD_DATA;
            S_RESP:  m_tvalid = 1'b1;
            default: ctl.cmd = CMD_NONE;
        endcase
    end

endmodule

// ----- src/vlmr_dp.sv -----
// Datapath of the message ring: byte store, pointers, counters and the
// result registers, driven by commands from vlmr_ctrl. Depends on vlmr_pkg.
`timescale 1ns / 1ps

module vlmr_dp
    import vlmr_pkg::*;
#(
    parameter int RING_BYTES   = 4096,
    parameter int HEADER_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    input  logic [1:0]  kind,
    input  logic [7:0]  data,
    input  logic [11:0] msg_len,
    input  logic [11:0] max_len,
    output stat_t       stat,
    output logic [2:0]  status,
    output logic [7:0]  data_res,
    output logic [11:0] msg_len_res,
    output logic [15:0] seq,
    output logic        last
);

    localparam int PW  = $clog2(RING_BYTES);
    localparam int CW  = $clog2(RING_BYTES + 1);
    localparam int SW  = ((CW > 13) ? CW : 13) + 1;
    localparam int HCW = $clog2(HEADER_BYTES);

    // pointer sum below twice the ring size folded back into range
    function automatic logic [PW-1:0] wrap_ptr(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        begin
            r = (s >= SW'(RING_BYTES)) ? (s - SW'(RING_BYTES)) : s;
            return r[PW-1:0];
        end
    endfunction

    // byte store
    logic [7:0]    ring_mem [RING_BYTES];
    logic          mem_we;
    logic [PW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_q;

    // control state
    logic [PW-1:0]  wp_reg, wp_next;
    logic [PW-1:0]  rp_reg, rp_next;
    logic [PW-1:0]  rdptr_reg, rdptr_next;
    logic [CW-1:0]  committed_reg, committed_next;
    logic [15:0]    wseq_reg, wseq_next;
    logic [15:0]    rseq_reg, rseq_next;
    logic [11:0]    wr_rem_reg, wr_rem_next;
    logic [11:0]    rd_rem_reg, rd_rem_next;
    logic [HCW-1:0] hdr_cnt_reg, hdr_cnt_next;

    // payload registers
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    logic [11:0] mlen_reg, mlen_next;
    logic [11:0] mmax_reg, mmax_next;
    logic [11:0] open_len_reg, open_len_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [11:0] head_len_reg, head_len_next;
    logic [2:0]  res_status_reg, res_status_next;
    logic [7:0]  res_data_reg, res_data_next;
    logic [11:0] res_len_reg, res_len_next;
    logic [15:0] res_seq_reg, res_seq_next;
    logic        res_last_reg, res_last_next;

    logic [4:0]    hdr_idx;
    logic [7:0]    hdr_byte;
    logic [PW-1:0] wp_after_hdr;
    logic [PW-1:0] wp_after_pay;
    logic [SW-1:0] space_sum;

    // header byte for the current header slot
    assign hdr_idx = 5'(hdr_cnt_reg);
    always_comb
    begin
        case (hdr_idx)
            5'd0:    hdr_byte = mlen_reg[7:0];
            5'd1:    hdr_byte = {4'b0000, mlen_reg[11:8]};
            5'd2:    hdr_byte = wseq_reg[7:0];
            5'd3:    hdr_byte = wseq_reg[15:8];
            default: hdr_byte = 8'h00;
        endcase
    end

    assign wp_after_hdr = wrap_ptr(SW'(wp_reg) + SW'(HEADER_BYTES));
    assign wp_after_pay = wrap_ptr(SW'(wp_reg) + SW'(1));
    assign space_sum    = SW'(mlen_reg) + SW'(HEADER_BYTES) + SW'(committed_reg);

    // status to the controller
    always_comb
    begin
        stat.kind      = kind_reg;
        stat.wr_open   = (wr_rem_reg != 12'd0);
        stat.space_ok  = (space_sum <= SW'(RING_BYTES));
        stat.empty     = (committed_reg == CW'(0));
        stat.rd_at_hdr = (rd_rem_reg == 12'd0);
        stat.too_long  = (head_len_reg > mmax_reg);
        stat.len_zero  = (head_len_reg == 12'd0);
        stat.hdr_done  = (hdr_cnt_reg == HCW'(HEADER_BYTES - 1));
    end

    // memory port address and write select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = rp_reg;
        mem_wdata = data_reg;
        unique case (ctl.cmd)
            CMD_HDR:
            begin
                mem_we    = 1'b1;
                mem_addr  = wrap_ptr(SW'(wp_reg) + SW'(hdr_cnt_reg));
                mem_wdata = hdr_byte;
            end
            CMD_PAY:
            begin
                mem_we   = 1'b1;
                mem_addr = wp_reg;
            end
            CMD_RD_H0:    mem_addr = rp_reg;
            CMD_RD_H1:    mem_addr = wrap_ptr(SW'(rp_reg) + SW'(1));
            CMD_RD_START: mem_addr = wrap_ptr(SW'(rp_reg) + SW'(HEADER_BYTES));
            CMD_RD_ADDR:  mem_addr = rdptr_reg;
            default:      mem_addr = rp_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_addr] <= mem_wdata;
        end
        mem_q <= ring_mem[mem_addr];
    end

    // next values for every command
    always_comb
    begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        rdptr_next      = rdptr_reg;
        committed_next  = committed_reg;
        wseq_next       = wseq_reg;
        rseq_next       = rseq_reg;
        wr_rem_next     = wr_rem_reg;
        rd_rem_next     = rd_rem_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        kind_next       = kind_reg;
        data_next       = data_reg;
        mlen_next       = mlen_reg;
        mmax_next       = mmax_reg;
        open_len_next   = open_len_reg;
        len_lo_next     = len_lo_reg;
        head_len_next   = head_len_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_len_next    = res_len_reg;
        res_seq_next    = res_seq_reg;
        res_last_next   = res_last_reg;
        unique case (ctl.cmd)
            CMD_LATCH:
            begin
                kind_next    = kind;
                data_next    = data;
                mlen_next    = msg_len;
                mmax_next    = max_len;
                hdr_cnt_next = HCW'(0);
            end
            CMD_RESULT:
            begin
                res_status_next = ctl.status;
                res_data_next   = 8'h00;
                res_last_next   = 1'b0;
                res_len_next    = 12'd0;
                res_seq_next    = 16'd0;
                case (ctl.status)
                    ST_NO_SPACE:
                    begin
                        res_len_next = mlen_reg;
                        res_seq_next = wseq_reg;
                    end
                    ST_EMPTY:
                    begin
                        res_seq_next = rseq_reg;
                    end
                    ST_TOO_LONG:
                    begin
                        res_len_next = head_len_reg;
                        res_seq_next = rseq_reg;
                    end
                    default:
                    begin
                        res_seq_next = 16'd0;
                    end
                endcase
            end
            CMD_HDR:
            begin
                hdr_cnt_next = hdr_cnt_reg + HCW'(1);
                if (hdr_cnt_reg == HCW'(HEADER_BYTES - 1))
                begin
                    wp_next         = wp_after_hdr;
                    wseq_next       = wseq_reg + 16'd1;
                    wr_rem_next     = mlen_reg;
                    open_len_next   = mlen_reg;
                    res_status_next = ST_OK;
                    res_data_next   = 8'h00;
                    res_len_next    = mlen_reg;
                    res_seq_next    = wseq_reg;
                    res_last_next   = 1'b0;
                    // empty message commits right away
                    if (mlen_reg == 12'd0)
                    begin
                        committed_next = CW'(SW'(committed_reg) + SW'(HEADER_BYTES));
                    end
                end
            end
            CMD_PAY:
            begin
                wp_next         = wp_after_pay;
                wr_rem_next     = wr_rem_reg - 12'd1;
                res_status_next = ST_OK;
                res_data_next   = 8'h00;
                res_len_next    = 12'd0;
                res_seq_next    = wseq_reg - 16'd1;
                res_last_next   = 1'b0;
                // last payload byte makes the message visible
                if (wr_rem_reg == 12'd1)
                begin
                    committed_next = CW'(SW'(committed_reg) + SW'(open_len_reg)
                                         + SW'(HEADER_BYTES));
                end
            end
            CMD_RD_H1:
            begin
                len_lo_next = mem_q;
            end
            CMD_RD_LEN:
            begin
                head_len_next = {mem_q[3:0], len_lo_reg};
            end
            CMD_RD_ZERO:
            begin
                res_status_next = ST_OK;
                res_data_next   = 8'h00;
                res_len_next    = 12'd0;
                res_seq_next    = rseq_reg;
                res_last_next   = 1'b1;
                rp_next         = wrap_ptr(SW'(rp_reg) + SW'(HEADER_BYTES));
                committed_next  = CW'(SW'(committed_reg) - SW'(HEADER_BYTES));
                rseq_next       = rseq_reg + 16'd1;
            end
            CMD_RD_START:
            begin
                rd_rem_next = head_len_reg;
                rdptr_next  = wrap_ptr(SW'(wrap_ptr(SW'(rp_reg) + SW'(HEADER_BYTES)))
                                       + SW'(1));
            end
            CMD_RD_ADDR:
            begin
                rdptr_next = wrap_ptr(SW'(rdptr_reg) + SW'(1));
            end
            CMD_RD_DATA:
            begin
                rd_rem_next     = rd_rem_reg - 12'd1;
                res_status_next = ST_OK;
                res_data_next   = mem_q;
                res_len_next    = head_len_reg;
                res_seq_next    = rseq_reg;
                res_last_next   = (rd_rem_reg == 12'd1);
                // final byte frees the whole message
                if (rd_rem_reg == 12'd1)
                begin
                    rp_next        = wrap_ptr(SW'(rp_reg) + SW'(head_len_reg)
                                              + SW'(HEADER_BYTES));
                    committed_next = CW'(SW'(committed_reg) - SW'(head_len_reg)
                                         - SW'(HEADER_BYTES));
                    rseq_next      = rseq_reg + 16'd1;
                end
            end
            default:
            begin
                hdr_cnt_next = hdr_cnt_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            rdptr_reg     <= '0;
            committed_reg <= '0;
            wseq_reg      <= '0;
            rseq_reg      <= '0;
            wr_rem_reg    <= '0;
            rd_rem_reg    <= '0;
            hdr_cnt_reg   <= '0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            rdptr_reg     <= rdptr_next;
            committed_reg <= committed_next;
            wseq_reg      <= wseq_next;
            rseq_reg      <= rseq_next;
            wr_rem_reg    <= wr_rem_next;
            rd_rem_reg    <= rd_rem_next;
            hdr_cnt_reg   <= hdr_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        data_reg       <= data_next;
        mlen_reg       <= mlen_next;
        mmax_reg       <= mmax_next;
        open_len_reg   <= open_len_next;
        len_lo_reg     <= len_lo_next;
        head_len_reg   <= head_len_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_len_reg    <= res_len_next;
        res_seq_reg    <= res_seq_next;
        res_last_reg   <= res_last_next;
    end

    assign status      = res_status_reg;
    assign data_res    = res_data_reg;
    assign msg_len_res = res_len_reg;
    assign seq         = res_seq_reg;
    assign last        = res_last_reg;

endmodule

// ----- src/variable_length_message_ring_top.sv -----
// Top level of the variable-length message ring: sequencer plus datapath.
// Depends on vlmr_pkg, vlmr_ctrl and vlmr_dp.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid / s_tready  s_tuser kind, s_tdata data, msg_len, max_len
//   m_*      out  m_tvalid / m_tready  m_tdata result fields, m_tlast last
//
// One item at a time; the next item is taken only after the last result is taken.
// A payload write stores its byte, an open writes the HEADER_BYTES header bytes, a
// refusal is found at decode, a read inside a message reads one data byte, and a read
// at a message start reads the two length bytes of the header, then the data byte unless
// it is too long or has no payload (all reads on the single store port, each registered).
// The result stays on m_* until taken; the next item is accepted the cycle after.
// Reset clears pointers, counts and sequence numbers; the store is not cleared.
`timescale 1ns / 1ps

module variable_length_message_ring_top
    import vlmr_pkg::*;
#(
    parameter int RING_BYTES   = 4096,
    parameter int HEADER_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data[7:0], msg_len[19:8], max_len[31:20]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[2:0], data_res[10:3], msg_len_res[22:11],
                                   // seq[38:23], zero[39]
    output logic        m_tlast    // last
);

    ctl_t        ctl;
    stat_t       stat;
    logic [2:0]  status;
    logic [7:0]  data_res;
    logic [11:0] msg_len_res;
    logic [15:0] seq;
    logic        last;

    vlmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    vlmr_dp #(
        .RING_BYTES   (RING_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .kind        (s_tuser),
        .data        (s_tdata[7:0]),
        .msg_len     (s_tdata[19:8]),
        .max_len     (s_tdata[31:20]),
        .stat        (stat),
        .status      (status),
        .data_res    (data_res),
        .msg_len_res (msg_len_res),
        .seq         (seq),
        .last        (last)
    );

    // result packing
    assign m_tdata = {1'b0, seq, msg_len_res, data_res, status};
    assign m_tlast = last;

endmodule

// ----- tb/sv/variable_length_message_ring_top_tb.sv -----
// Self-checking testbench for the variable-length message ring top level.
// Depends on vlmr_pkg and variable_length_message_ring_top; an internal ring predictor
// checks every result item, with random idling on both stream channels.
`timescale 1ns / 1ps

module variable_length_message_ring_top_tb;
    import vlmr_pkg::*;

    localparam int          RING_BYTES   = 4096;
    localparam int          HEADER_BYTES = 4;
    localparam logic [11:0] MAX_LEN      = 12'd4092;
    localparam int          RANDOM_ITEMS = 380;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          IDLE_LIMIT   = 3000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          MAX_REPORTS  = 40;

    // kind code the block does not define
    localparam logic [1:0] KIND_BAD = 2'd3;

    // result item as carried on m_tdata / m_tlast
    typedef struct packed {
        status_t     status;
        logic [7:0]  data;
        logic [11:0] msg_len;
        logic [15:0] seq;
        logic        last;
    } ring_result_t;

    // receiver ready patterns
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_EVERY_FOURTH,
        READY_MOSTLY
    } sink_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // data[7:0], msg_len[19:8], max_len[31:20]
    logic [1:0]  s_tuser;    // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // status[2:0], data_res[10:3], msg_len_res[22:11], seq[38:23]
    logic        m_tlast;    // last

    // predicted ring contents and pointers
    logic [7:0]  ring_bytes [RING_BYTES];
    logic [11:0] wr_ptr;
    logic [11:0] commit_ptr;
    logic [11:0] rd_ptr;
    logic [12:0] used_bytes;
    logic [12:0] wr_left;
    logic [12:0] rd_left;
    logic [15:0] wr_seq;
    logic [15:0] rd_seq;

    ring_result_t pending_results [$];
    int           fail_count   = 0;
    int           report_count = 0;
    int           burst_left   = 0;
    bit           hold_request = 1'b0;

    variable_length_message_ring_top #(
        .RING_BYTES   (RING_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [11:0] ring_wrap(int unsigned p);
        return 12'(p % RING_BYTES);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [11:0] rand_len(int unsigned lo);
        return 12'($urandom_range(lo, MAX_LEN));
    endfunction

    // 12-bit length from the two low header bytes
    function automatic logic [11:0] stored_len(logic [11:0] p);
        return {ring_bytes[ring_wrap(int'(p) + 1)][3:0], ring_bytes[p]};
    endfunction

    // the open message is the only uncommitted one
    function automatic void commit_message();
        used_bytes = 13'(int'(used_bytes) + int'(stored_len(commit_ptr)) + HEADER_BYTES);
        commit_ptr = wr_ptr;
    endfunction

    // next result of the ring for one item; updates the predicted state
    function automatic ring_result_t predict_ring_result(logic [1:0] kind, logic [7:0] data,
                                                         logic [11:0] mlen, logic [11:0] mmax);
        ring_result_t r;
        logic [11:0]  hlen;
        logic [7:0]   hbyte;
        int           i;
        r = '0;
        r.status = ST_SEQ_ERR;
        case (kind)
            KIND_OPEN:
                if (wr_left == 0)
                begin
                    r.seq     = wr_seq;
                    r.msg_len = mlen;
                    if (int'(mlen) + HEADER_BYTES > RING_BYTES - int'(used_bytes))
                        r.status = ST_NO_SPACE;
                    else
                    begin
                        r.status = ST_OK;
                        // header: length low/high, sequence low/high, then zeros
                        for (i = 0; i < HEADER_BYTES; i++)
                        begin
                            case (i)
                                0:       hbyte = mlen[7:0];
                                1:       hbyte = {4'h0, mlen[11:8]};
                                2:       hbyte = wr_seq[7:0];
                                3:       hbyte = wr_seq[15:8];
                                default: hbyte = 8'h00;
                            endcase
                            ring_bytes[ring_wrap(int'(wr_ptr) + i)] = hbyte;
                        end
                        wr_ptr  = ring_wrap(int'(wr_ptr) + HEADER_BYTES);
                        wr_seq  = wr_seq + 16'd1;
                        wr_left = {1'b0, mlen};
                        if (mlen == 0)
                            commit_message();
                    end
                end
            KIND_PAY:
                if (wr_left != 0)
                begin
                    r.status = ST_OK;
                    r.seq    = wr_seq - 16'd1;
                    ring_bytes[wr_ptr] = data;
                    wr_ptr  = ring_wrap(int'(wr_ptr) + 1);
                    wr_left = wr_left - 13'd1;
                    if (wr_left == 0)
                        commit_message();
                end
            KIND_READ:
            begin
                r.seq = rd_seq;
                if (used_bytes == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    hlen      = stored_len(rd_ptr);
                    r.msg_len = hlen;
                    // the limit only applies at the start of a message
                    if (rd_left == 0 && hlen > mmax)
                        r.status = ST_TOO_LONG;
                    else
                    begin
                        r.status = ST_OK;
                        if (rd_left == 0)
                            rd_left = {1'b0, hlen};
                        if (rd_left != 0)
                        begin
                            r.data  = ring_bytes[ring_wrap(int'(rd_ptr) + HEADER_BYTES
                                                           + int'(hlen) - int'(rd_left))];
                            rd_left = rd_left - 13'd1;
                        end
                        if (rd_left == 0)
                        begin
                            r.last     = 1'b1;
                            rd_ptr     = ring_wrap(int'(rd_ptr) + int'(hlen) + HEADER_BYTES);
                            used_bytes = 13'(int'(used_bytes) - int'(hlen) - HEADER_BYTES);
                            rd_seq     = rd_seq + 16'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // offer one item; bursts with random gaps in between
    task automatic send_ring_item(input logic [1:0] kind, input logic [7:0] data,
                                  input logic [11:0] mlen, input logic [11:0] mmax);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {mmax, mlen, data};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_ring_result(kind, data, mlen, mmax));
    endtask

    task automatic fill_payload(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_ring_item(KIND_PAY, rand_byte(), rand_len(0), rand_len(0));
    endtask

    task automatic write_message(input int len);
        send_ring_item(KIND_OPEN, rand_byte(), 12'(len), rand_len(0));
        fill_payload(len);
    endtask

    // first read must pass the limit; later ones use any limit
    task automatic read_message(input int len);
        int i;
        send_ring_item(KIND_READ, rand_byte(), rand_len(0), rand_len(len));
        for (i = 1; i < len; i++)
            send_ring_item(KIND_READ, rand_byte(), rand_len(0), rand_len(0));
    endtask

    // error codes, zero-length message, limits, field extremes
    task automatic test_directed_cases();
        send_ring_item(KIND_READ, 8'h00, 12'd0, 12'd0);        // empty ring
        send_ring_item(KIND_PAY, 8'h5A, 12'd0, 12'd0);         // nothing open
        send_ring_item(KIND_BAD, 8'hFF, MAX_LEN, MAX_LEN);
        send_ring_item(KIND_OPEN, 8'h00, 12'd0, 12'd0);        // zero length, committed at once
        send_ring_item(KIND_READ, 8'h00, 12'd0, 12'd0);
        send_ring_item(KIND_OPEN, 8'h00, 12'd3, 12'd0);
        send_ring_item(KIND_OPEN, 8'h00, 12'd5, 12'd0);        // already open
        send_ring_item(KIND_PAY, 8'h00, 12'd0, 12'd0);
        send_ring_item(KIND_PAY, 8'hFF, MAX_LEN, MAX_LEN);
        send_ring_item(KIND_PAY, 8'hA5, 12'd0, 12'd0);
        send_ring_item(KIND_READ, 8'h00, 12'd0, 12'd2);        // longer than the limit
        send_ring_item(KIND_READ, 8'h00, 12'd0, 12'd3);
        send_ring_item(KIND_READ, 8'h00, 12'd0, 12'd0);        // started, limit ignored
        send_ring_item(KIND_READ, 8'h00, 12'd0, 12'd0);
        send_ring_item(KIND_OPEN, 8'h00, 12'd2, 12'd0);
        send_ring_item(KIND_PAY, 8'h3C, 12'd0, 12'd0);
        send_ring_item(KIND_PAY, 8'hC3, 12'd0, 12'd0);
        send_ring_item(KIND_OPEN, 8'h00, MAX_LEN, 12'd0);      // no room
        send_ring_item(KIND_READ, 8'h00, 12'd0, MAX_LEN);
        send_ring_item(KIND_READ, 8'h00, 12'd0, MAX_LEN);
        send_ring_item(KIND_READ, 8'h00, 12'd0, MAX_LEN);      // empty again
    endtask

    // opens at the free-space boundary: one byte too many, then an exact fit
    task automatic test_exact_fit();
        int fit_len;
        int i;
        if (wr_left != 0)
            fill_payload(int'(wr_left));
        write_message(5);
        fit_len = RING_BYTES - int'(used_bytes) - HEADER_BYTES;
        send_ring_item(KIND_OPEN, 8'h00, 12'(fit_len + 1), MAX_LEN);
        send_ring_item(KIND_OPEN, 8'h00, 12'(fit_len), MAX_LEN);
        send_ring_item(KIND_OPEN, 8'h00, 12'd1, MAX_LEN);      // already open
        fill_payload(4);
        // big message is still uncommitted; drain what is ahead of it
        for (i = 0; i < 8; i++)
            send_ring_item(KIND_READ, 8'h00, 12'd0, MAX_LEN);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        write_message(6);
        read_message(6);
    endtask

    // mostly well-formed traffic, some noise and refused opens
    task automatic test_random_traffic();
        int          n;
        int          pick;
        int          lo;
        logic [11:0] len;
        logic [11:0] limit;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick  = $urandom_range(0, 99);
            limit = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 12)) : rand_len(0);
            lo = RING_BYTES - int'(used_bytes) - HEADER_BYTES + 1;
            if ($urandom_range(0, 9) == 0 && lo <= MAX_LEN)
                len = rand_len(lo);
            else
                len = 12'($urandom_range(0, 16));
            if (pick < 6)
            begin
                // bad kind, or the write command that cannot be taken now
                if (pick < 2)
                    send_ring_item(KIND_BAD, rand_byte(), len, limit);
                else if (wr_left != 0)
                    send_ring_item(KIND_OPEN, rand_byte(), len, limit);
                else
                    send_ring_item(KIND_PAY, rand_byte(), len, limit);
            end
            else if (wr_left != 0)
            begin
                if (pick < 75)
                    send_ring_item(KIND_PAY, rand_byte(), len, limit);
                else
                    send_ring_item(KIND_READ, rand_byte(), len, limit);
            end
            else if ((used_bytes == 0) ? (pick < 85) : (pick < 35))
                send_ring_item(KIND_OPEN, rand_byte(), len, limit);
            else
                send_ring_item(KIND_READ, rand_byte(), len, limit);
        end
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (report_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            report_count++;
        end
    endfunction

    // compare each result item with the oldest prediction
    always @(posedge clk)
    begin : result_check
        ring_result_t want;
        ring_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = ring_result_t'({m_tdata[2:0], m_tdata[10:3], m_tdata[22:11], m_tdata[38:23],
                                  m_tlast});
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                report_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(got.status));
                check_field("data", 16'(want.data), 16'(got.data));
                check_field("msg_len", 16'(want.msg_len), 16'(got.msg_len));
                check_field("seq", want.seq, got.seq);
                check_field("last", 16'(want.last), 16'(got.last));
            end
        end
    end

    // receiver: ready patterns in random stretches, plus a long hold on request
    initial
    begin : result_sink
        sink_mode_t mode;
        int         stretch;
        int         hold;
        int         tick;
        mode    = READY_ALWAYS;
        stretch = 0;
        hold    = 0;
        tick    = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode    = sink_mode_t'($urandom_range(0, 3));
                    stretch = $urandom_range(16, 128);
                end
                stretch--;
                case (mode)
                    READY_ALWAYS:       m_tready <= 1'b1;
                    READY_COIN:         m_tready <= ($urandom_range(0, 1) == 1);
                    READY_EVERY_FOURTH: m_tready <= (tick % 4 == 0);
                    default:            m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ends the run when no item moves on either channel for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** variable_length_message_ring_top: FAILED **");
        $finish;
    end

    initial
    begin : main_sequence
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        foreach (ring_bytes[i])
            ring_bytes[i] = 8'h00;
        wr_ptr     = '0;
        commit_ptr = '0;
        rd_ptr     = '0;
        used_bytes = '0;
        wr_left    = '0;
        rd_left    = '0;
        wr_seq     = '0;
        rd_seq     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_output_backpressure();
        test_random_traffic();
        test_exact_fit();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** variable_length_message_ring_top: PASSED **");
        else
            $display("** variable_length_message_ring_top: FAILED **");
        $finish;
    end

endmodule
